// File: rtl/core/cfdvpl_pkg.sv
package cfdvpl_pkg;

  // Register indexes of the configuration port
  localparam logic [2:0] CFG_VEL_EN  = 3'd0;
  localparam logic [2:0] CFG_PRES_EN = 3'd1;
  localparam logic [2:0] CFG_MAX_SPD = 3'd2;
  localparam logic [2:0] CFG_BND_A   = 3'd3;
  localparam logic [2:0] CFG_BND_B   = 3'd4;

  localparam int unsigned CNT_W   = 21;
  localparam int unsigned SQ_N    = 32;  // one root bit per stage
  localparam int unsigned DV_N    = 31;  // one quotient bit per stage
  localparam int unsigned LANES   = 3;

  // Per-cell data that rides alongside the arithmetic
  typedef struct packed {
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [31:0] p;
    logic        last;
    logic        vlim;
    logic        pcl;
    logic        cerr;
  } side_t;

endpackage

// File: rtl/core/cfd_cell_velocity_pressure_limiter.sv
// Cell velocity and pressure limiter.
// Input words on in_* carry one cell: velocity x, y, z and pressure (signed
// Q16.16) in tdata, the field's final cell marked by in_tlast. Each word gives
// one output word on out_*: limited velocity, clamped pressure and the running
// totals in tdata, per-cell flags in tuser, and field_done on out_tlast.
// Configuration is written through cfg_we / cfg_index / cfg_wdata; the user
// must do so only while the block holds no cells, which it does not enforce.
// One word is accepted every cycle unless the pipeline is held (see below).
// Most of the pipeline is the square root of the squared speed
// (32 stages, one root bit each) followed by the division by that root
// (31 stages, one quotient bit each, three components side by side).
// Throughput is one word per cycle while out_tready stays high.
// When out_tready is low with a word waiting, the whole pipeline holds and
// in_tready drops; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline, clears both counts, sets
// limiting and clamping off, max_speed to its top value and the bounds to the
// full signed range. The counts clear as a last word enters the output stage.
module cfd_cell_velocity_pressure_limiter
  import cfdvpl_pkg::*;
#(
  parameter int unsigned MAX_CELLS = 1048576
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vel_x, vel_y, vel_z, pressure_in
  input  logic [127:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // vel_x_out, vel_y_out, vel_z_out, pressure_out, velocity_total,
  // pressure_total, zero fill
  output logic [175:0] out_tdata,
  // velocity_limited, pressure_clamped, config_error
  output logic [2:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  localparam logic [CNT_W-1:0] CNT_CAP =
    (MAX_CELLS < ((1 << CNT_W) - 1)) ? CNT_W'(MAX_CELLS) : CNT_W'((1 << CNT_W) - 1);

  // Configuration registers
  logic        vel_en_r, pres_en_r;
  logic [30:0] max_spd_r;
  logic [31:0] bnd_a_r, bnd_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_en_r  <= 1'b0;
      pres_en_r <= 1'b0;
      max_spd_r <= '1;
      bnd_a_r   <= 32'h8000_0000;
      bnd_b_r   <= 32'h7FFF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VEL_EN:  vel_en_r  <= cfg_wdata[0];
        CFG_PRES_EN: pres_en_r <= cfg_wdata[0];
        CFG_MAX_SPD: max_spd_r <= cfg_wdata[30:0];
        CFG_BND_A:   bnd_a_r   <= cfg_wdata;
        CFG_BND_B:   bnd_b_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Whole pipeline advances whenever the output register can take a word
  logic adv;
  logic out_v_r;
  assign adv       = !out_v_r || out_tready;
  assign in_tready = adv;

  // Stage A: capture the cell and take magnitudes
  logic        a_v_r;
  side_t       a_side_r;
  logic [31:0] a_ax_r, a_ay_r, a_az_r;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (adv) a_v_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_side_r.vx   <= in_tdata[31:0];
      a_side_r.vy   <= in_tdata[63:32];
      a_side_r.vz   <= in_tdata[95:64];
      a_side_r.p    <= in_tdata[127:96];
      a_side_r.last <= in_tlast;
      a_side_r.vlim <= 1'b0;
      a_side_r.pcl  <= 1'b0;
      a_side_r.cerr <= 1'b0;
      a_ax_r <= mag32(in_tdata[31:0]);
      a_ay_r <= mag32(in_tdata[63:32]);
      a_az_r <= mag32(in_tdata[95:64]);
    end
  end

  // Stage B: squares, scaled numerators and the pressure clamp
  logic        b_v_r;
  side_t       b_side_r;
  side_t       b_side_nxt;
  logic [63:0] b_sqx_r, b_sqy_r, b_sqz_r;
  logic [61:0] b_lim2_r;
  logic [62:0] b_n_r [LANES];

  logic signed [31:0] p_a, p_b, p_in, p_lo, p_hi, p_c;
  always_comb begin
    p_a  = bnd_a_r;
    p_b  = bnd_b_r;
    p_in = a_side_r.p;
    p_lo = (p_a < p_b) ? p_a : p_b;
    p_hi = (p_a < p_b) ? p_b : p_a;
    if (p_in < p_lo)      p_c = p_lo;
    else if (p_in > p_hi) p_c = p_hi;
    else                  p_c = p_in;
  end

  // Merge the clamped pressure and its flags into the side data
  always_comb begin
    b_side_nxt      = a_side_r;
    b_side_nxt.p    = pres_en_r ? p_c : p_in;
    b_side_nxt.pcl  = pres_en_r && (p_c != p_in);
    b_side_nxt.cerr = pres_en_r && (p_a == p_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (adv) b_v_r <= a_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_side_r <= b_side_nxt;
      b_sqx_r  <= a_ax_r * a_ax_r;
      b_sqy_r  <= a_ay_r * a_ay_r;
      b_sqz_r  <= a_az_r * a_az_r;
      b_lim2_r <= max_spd_r * max_spd_r;
      b_n_r[0] <= a_ax_r * max_spd_r;
      b_n_r[1] <= a_ay_r * max_spd_r;
      b_n_r[2] <= a_az_r * max_spd_r;
    end
  end

  // Stage C: first partial sum of the squared magnitude
  logic        c_v_r;
  side_t       c_side_r;
  logic [63:0] c_sxy_r, c_sqz_r;
  logic [61:0] c_lim2_r;
  logic [62:0] c_n_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (adv) c_v_r <= b_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_side_r <= b_side_r;
      c_sxy_r  <= b_sqx_r + b_sqy_r;
      c_sqz_r  <= b_sqz_r;
      c_lim2_r <= b_lim2_r;
      c_n_r    <= b_n_r;
    end
  end

  // Stage D (root stage 0): full squared magnitude
  logic        sq_v_r    [0:SQ_N];
  side_t       sq_side_r [0:SQ_N];
  logic [63:0] sq_m2_r   [0:SQ_N];
  logic [33:0] sq_rem_r  [0:SQ_N];
  logic [31:0] sq_root_r [0:SQ_N];
  logic [62:0] sq_n_r    [0:SQ_N][LANES];
  logic [61:0] d_lim2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else if (adv) sq_v_r[0] <= c_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_side_r[0] <= c_side_r;
      sq_m2_r[0]   <= c_sxy_r + c_sqz_r;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_n_r[0]    <= c_n_r;
      d_lim2_r     <= c_lim2_r;
    end
  end

  // Square root stages: one root bit each
  for (genvar j = 1; j <= SQ_N; j++) begin : g_sqrt
    logic [35:0] r4, trial;
    logic        ge;
    side_t       sd;

    assign r4    = {sq_rem_r[j-1], sq_m2_r[j-1][63:62]};
    assign trial = {2'b00, sq_root_r[j-1], 2'b01};
    assign ge    = (r4 >= trial);

    if (j == 1) begin : g_cmp
      // Decide limiting alongside the first root step
      always_comb begin
        sd      = sq_side_r[0];
        sd.vlim = vel_en_r && (sq_m2_r[0] > {2'b00, d_lim2_r});
      end
    end else begin : g_pass
      assign sd = sq_side_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[j] <= 1'b0;
      else if (adv) sq_v_r[j] <= sq_v_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_side_r[j] <= sd;
        sq_m2_r[j]   <= {sq_m2_r[j-1][61:0], 2'b00};
        sq_rem_r[j]  <= ge ? 34'(r4 - trial) : r4[33:0];
        sq_root_r[j] <= {sq_root_r[j-1][30:0], ge};
        sq_n_r[j]    <= sq_n_r[j-1];
      end
    end
  end

  // Division stages: one quotient bit per stage, three components in parallel
  logic        dv_v_r    [1:DV_N];
  side_t       dv_side_r [1:DV_N];
  logic [31:0] dv_m_r    [1:DV_N];
  logic [31:0] dv_rem_r  [1:DV_N][LANES];
  logic [30:0] dv_low_r  [1:DV_N][LANES];
  logic [30:0] dv_q_r    [1:DV_N][LANES];

  for (genvar i = 1; i <= DV_N; i++) begin : g_div
    logic        src_v;
    side_t       src_side;
    logic [31:0] src_m;
    logic [31:0] src_rem [LANES];
    logic [30:0] src_low [LANES];
    logic [30:0] src_q   [LANES];
    logic [32:0] rt      [LANES];
    logic        qb      [LANES];

    if (i == 1) begin : g_first
      assign src_v    = sq_v_r[SQ_N];
      assign src_side = sq_side_r[SQ_N];
      assign src_m    = sq_root_r[SQ_N];
      for (genvar l = 0; l < LANES; l++) begin : g_ln
        assign src_rem[l] = sq_n_r[SQ_N][l][62:31];
        assign src_low[l] = sq_n_r[SQ_N][l][30:0];
        assign src_q[l]   = '0;
      end
    end else begin : g_next
      assign src_v    = dv_v_r[i-1];
      assign src_side = dv_side_r[i-1];
      assign src_m    = dv_m_r[i-1];
      assign src_rem  = dv_rem_r[i-1];
      assign src_low  = dv_low_r[i-1];
      assign src_q    = dv_q_r[i-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_step
      assign rt[l] = {src_rem[l], src_low[l][30]};
      assign qb[l] = (rt[l] >= {1'b0, src_m});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[i] <= 1'b0;
      else if (adv) dv_v_r[i] <= src_v;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_side_r[i] <= src_side;
        dv_m_r[i]    <= src_m;
        for (int l = 0; l < LANES; l++) begin
          dv_rem_r[i][l] <= qb[l] ? 32'(rt[l] - {1'b0, src_m}) : rt[l][31:0];
          dv_low_r[i][l] <= {src_low[l][29:0], 1'b0};
          dv_q_r[i][l]   <= {src_q[l][29:0], qb[l]};
        end
      end
    end
  end

  // Output stage: restore signs, update counts
  side_t            fin;
  logic [31:0]      vel_sel [LANES];
  logic [31:0]      vel_org [LANES];
  logic [CNT_W-1:0] vcnt_r, pcnt_r, vcnt_nxt, pcnt_nxt;
  logic [31:0]      o_vx_r, o_vy_r, o_vz_r, o_p_r;
  logic [CNT_W-1:0] o_vtot_r, o_ptot_r;
  logic             o_vlim_r, o_pcl_r, o_cerr_r, o_last_r;

  assign fin        = dv_side_r[DV_N];
  assign vel_org[0] = fin.vx;
  assign vel_org[1] = fin.vy;
  assign vel_org[2] = fin.vz;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (!fin.vlim)          vel_sel[l] = vel_org[l];
      else if (vel_org[l][31]) vel_sel[l] = ~{1'b0, dv_q_r[DV_N][l]} + 32'd1;
      else                    vel_sel[l] = {1'b0, dv_q_r[DV_N][l]};
    end
    vcnt_nxt = (fin.vlim && vcnt_r < CNT_CAP) ? vcnt_r + 1'b1 : vcnt_r;
    pcnt_nxt = (fin.pcl && pcnt_r < CNT_CAP) ? pcnt_r + 1'b1 : pcnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      vcnt_r  <= '0;
      pcnt_r  <= '0;
    end else if (adv) begin
      out_v_r <= dv_v_r[DV_N];
      if (dv_v_r[DV_N]) begin
        vcnt_r <= fin.last ? '0 : vcnt_nxt;
        pcnt_r <= fin.last ? '0 : pcnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_vx_r   <= vel_sel[0];
      o_vy_r   <= vel_sel[1];
      o_vz_r   <= vel_sel[2];
      o_p_r    <= fin.p;
      o_vtot_r <= vcnt_nxt;
      o_ptot_r <= pcnt_nxt;
      o_vlim_r <= fin.vlim;
      o_pcl_r  <= fin.pcl;
      o_cerr_r <= fin.cerr;
      o_last_r <= fin.last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b0, o_ptot_r, o_vtot_r, o_p_r, o_vz_r, o_vy_r, o_vx_r};
  assign out_tuser  = {o_cerr_r, o_pcl_r, o_vlim_r};
  assign out_tlast  = o_last_r;

  // Checks
  a_lim_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && o_vlim_r |-> mag32(o_vx_r) <= {1'b0, max_spd_r})
    else $error("limited x component exceeds max_speed");

  a_vlim_en: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !vel_en_r |-> !o_vlim_r)
    else $error("velocity limited while limiting is off");

  a_pcl_en: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !pres_en_r |-> !o_pcl_r && !o_cerr_r)
    else $error("pressure flags set while clamping is off");

  a_cnt_clr: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_tready && o_last_r && !dv_v_r[DV_N] |=> vcnt_r == '0 && pcnt_r == '0)
    else $error("counts not cleared after last cell");

endmodule

// File: dv/cfd_cell_velocity_pressure_limiter_tb.sv
`timescale 1ns / 100ps

module cfd_cell_velocity_pressure_limiter_tb;
  import cfdvpl_pkg::*;

  localparam int unsigned CELL_CAP   = 1048576;
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned DRAIN_WAIT = 80;

  typedef struct packed {
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [31:0] p;
    logic        last;
  } cell_t;

  typedef struct packed {
    logic [31:0]      vx;
    logic [31:0]      vy;
    logic [31:0]      vz;
    logic [31:0]      p;
    logic             vlim;
    logic             pcl;
    logic [CNT_W-1:0] vtot;
    logic [CNT_W-1:0] ptot;
    logic             done;
    logic             cerr;
  } limited_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [175:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_wdata = '0;

  // shadow of the block's registers and counts
  logic              vel_on, pres_on;
  logic [30:0]       speed_limit;
  logic [31:0]       bound_a, bound_b;
  logic [CNT_W-1:0]  vel_count, pres_count;

  cell_t    pending_cells[$];
  limited_t limited_q[$];
  int       fails = 0;
  int       snd_idle = 0;
  int       rcv_idle = 0;
  int       hold_req = 0;
  int       hold_seen = 0;
  int       hold_left = 0;
  logic     took = 1'b0;

  cfd_cell_velocity_pressure_limiter dut (.*);

  always #5 clk = ~clk;

  function automatic logic [63:0] root_floor(input logic [63:0] sq);
    logic [63:0] r;
    logic [63:0] trial;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = r | (64'd1 << i);
      if (trial * trial <= sq) r = trial;
    end
    return r;
  endfunction

  function automatic logic [31:0] shrink(input logic signed [31:0] v,
                                         input logic [63:0] lim, input logic [63:0] mag);
    logic [63:0] av;
    logic [63:0] q;
    av = v[31] ? 64'(-64'(signed'(v))) : 64'(v);
    q = (av * lim) / mag;
    return v[31] ? 32'(-q) : 32'(q);
  endfunction

  // work out one cell's result and advance the counts
  function automatic limited_t limit_cell(input cell_t c);
    limited_t r;
    logic [63:0] ax, ay, az, m2, lim, mag;
    logic signed [31:0] lo, hi, pv;
    r = '0;
    r.vx = c.vx; r.vy = c.vy; r.vz = c.vz; r.p = c.p; r.done = c.last;
    if (vel_on) begin
      ax = c.vx[31] ? 64'(-64'(signed'(c.vx))) : 64'(c.vx);
      ay = c.vy[31] ? 64'(-64'(signed'(c.vy))) : 64'(c.vy);
      az = c.vz[31] ? 64'(-64'(signed'(c.vz))) : 64'(c.vz);
      m2 = ax * ax + ay * ay + az * az;
      lim = 64'(speed_limit);
      if (m2 > lim * lim) begin
        mag = root_floor(m2);
        if (mag == 0) mag = 1;
        r.vx = shrink(c.vx, lim, mag);
        r.vy = shrink(c.vy, lim, mag);
        r.vz = shrink(c.vz, lim, mag);
        r.vlim = 1'b1;
      end
    end
    if (pres_on) begin
      lo = ($signed(bound_a) < $signed(bound_b)) ? bound_a : bound_b;
      hi = ($signed(bound_a) < $signed(bound_b)) ? bound_b : bound_a;
      pv = c.p;
      if (pv < lo) pv = lo;
      else if (pv > hi) pv = hi;
      r.cerr = (bound_a == bound_b);
      if (pv != $signed(c.p)) begin
        r.p = pv;
        r.pcl = 1'b1;
      end
    end
    if (r.vlim && vel_count < CELL_CAP) vel_count = vel_count + 1'b1;
    if (r.pcl && pres_count < CELL_CAP) pres_count = pres_count + 1'b1;
    r.vtot = vel_count;
    r.ptot = pres_count;
    if (c.last) begin
      vel_count = '0;
      pres_count = '0;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fails++;
    end
  endtask

  // drive input words; advance only once the current word has been taken
  always @(negedge clk) begin : driver
    cell_t c;
    if (rst_n && (!in_tvalid || took)) begin
      if (pending_cells.size() > 0 && $urandom_range(99) >= snd_idle) begin
        c = pending_cells.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {c.p, c.vz, c.vy, c.vx};
        in_tlast  <= c.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver readiness, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_LEN;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // predict on accepted input words, check accepted output words
  always @(posedge clk) begin : monitor
    limited_t w;
    took <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      limited_q.push_back(limit_cell(cell_t'({in_tdata[31:0], in_tdata[63:32],
        in_tdata[95:64], in_tdata[127:96], in_tlast})));
    if (rst_n && out_tvalid && out_tready) begin
      if (limited_q.size() == 0) begin
        $error("output word with no cell outstanding");
        fails++;
      end else begin
        w = limited_q.pop_front();
        check_field("vel_x_out", w.vx, out_tdata[31:0]);
        check_field("vel_y_out", w.vy, out_tdata[63:32]);
        check_field("vel_z_out", w.vz, out_tdata[95:64]);
        check_field("pressure_out", w.p, out_tdata[127:96]);
        check_field("velocity_total", 32'(w.vtot), 32'(out_tdata[148:128]));
        check_field("pressure_total", 32'(w.ptot), 32'(out_tdata[169:149]));
        check_field("zero_fill", 32'd0, 32'(out_tdata[175:170]));
        check_field("velocity_limited", 32'(w.vlim), 32'(out_tuser[0]));
        check_field("pressure_clamped", 32'(w.pcl), 32'(out_tuser[1]));
        check_field("config_error", 32'(w.cerr), 32'(out_tuser[2]));
        check_field("field_done", 32'(w.done), 32'(out_tlast));
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_VEL_EN:  vel_on = val[0];
      CFG_PRES_EN: pres_on = val[0];
      CFG_MAX_SPD: speed_limit = val[30:0];
      CFG_BND_A:   bound_a = val;
      CFG_BND_B:   bound_b = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic ven, input logic pen, input logic [31:0] spd,
                            input logic [31:0] a, input logic [31:0] b);
    write_reg(CFG_VEL_EN, {31'd0, ven});
    write_reg(CFG_PRES_EN, {31'd0, pen});
    write_reg(CFG_MAX_SPD, spd);
    write_reg(CFG_BND_A, a);
    write_reg(CFG_BND_B, b);
  endtask

  task automatic add_cell(input logic [31:0] vx, vy, vz, p, input logic last);
    pending_cells.push_back(cell_t'({vx, vy, vz, p, last}));
  endtask

  // hold the sender until every cell has come back and the pipe is quiet
  task automatic drain();
    wait (pending_cells.size() == 0 && !in_tvalid && limited_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_comp(input logic [31:0] spd);
    logic [31:0] v;
    case ($urandom_range(4))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(31);
      2: v = $urandom_range(spd);
      3: v = ($urandom_range(3) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: v = $urandom_range(spd / 2 + 1);
    endcase
    return $urandom_range(1) ? v : -v;
  endfunction

  initial begin
    logic [31:0] spd, a, b;
    vel_on = 0; pres_on = 0; speed_limit = 31'h7FFF_FFFF;
    bound_a = 32'h8000_0000; bound_b = 32'h7FFF_FFFF;
    vel_count = '0; pres_count = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    snd_idle = 23; rcv_idle = 82;

    // limiting off after reset: extremes pass through
    add_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 1'b0);
    add_cell(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    add_cell(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    drain();

    // unit speed limit, bounds written high first
    set_limits(1'b1, 1'b1, 32'h0001_0000, 32'h0064_0000, 32'hFF9C_0000);
    write_reg(3'd7, 32'hFFFF_FFFF);
    add_cell(32'h0, 32'h0, 32'h0, 32'h0064_0000, 1'b0);
    add_cell(32'h0000_8000, 32'h0, 32'h0, 32'h0064_0001, 1'b0);
    add_cell(32'h0003_0000, 32'hFFFC_0000, 32'h0, 32'hFF9B_FFFF, 1'b0);
    add_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    add_cell(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 1'b1);
    add_cell(32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b0);
    add_cell(32'h0, 32'h0001_0001, 32'h0, 32'h0, 1'b1);
    drain();

    // zero speed limit and equal bounds
    set_limits(1'b1, 1'b1, 32'h0, 32'h0002_0000, 32'h0002_0000);
    add_cell(32'h0, 32'h0, 32'h0, 32'h0002_0000, 1'b0);
    add_cell(32'h0000_0001, 32'h0, 32'h0, 32'h0, 1'b0);
    add_cell(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    drain();

    // top speed limit, full-range bounds, limiting of extreme velocities
    set_limits(1'b1, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    add_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    add_cell(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b0);
    add_cell(32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b1);
    add_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h1234_5678, 1'b0);
    drain();

    // random phases with varying limits
    for (int ph = 0; ph < 11; ph++) begin
      if (ph == 4) begin snd_idle = 82; rcv_idle = 23; end
      if (ph == 8) begin snd_idle = 0; rcv_idle = 0; end
      case ($urandom_range(3))
        0: spd = 32'h7FFF_FFFF;
        1: spd = 32'h0;
        2: spd = $urandom;
        default: spd = $urandom_range(32'h0100_0000, 32'h0000_1000);
      endcase
      a = $urandom >> $urandom_range(8);
      a = $urandom_range(1) ? a : -a;
      case ($urandom_range(3))
        0: b = a;
        1: b = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        default: begin
          b = $urandom >> $urandom_range(8);
          b = $urandom_range(1) ? b : -b;
        end
      endcase
      set_limits($urandom_range(4) != 0, $urandom_range(4) != 0, spd, a, b);
      // long receiver hold-off while the sender keeps offering
      if (ph == 9) hold_req++;
      for (int i = 0; i < 50; i++)
        add_cell(rand_comp(spd[30:0]), rand_comp(spd[30:0]), rand_comp(spd[30:0]),
                 ($urandom_range(3) == 0) ? rand_comp(a) : $urandom,
                 $urandom_range(15) == 0);
      drain();
    end

    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
